>>> rtl/core/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CountW  = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_CHAR_A       = 2'd0,
    REG_START_CHAR_B       = 2'd1,
    REG_MAX_PAYLOAD        = 2'd2,
    REG_IDLE_TIMEOUT_TICKS = 2'd3
  } cfg_reg_t;

  localparam logic [ByteW-1:0] StartCharAReset = 8'd5;
  localparam logic [ByteW-1:0] StartCharBReset = 8'd5;
  localparam logic [ByteW-1:0] MaxPayloadReset = 8'd64;
  localparam logic [ByteW-1:0] IdleTicksReset  = 8'd3;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_ADDRESS  = 3'd1,
    KIND_LENGTH   = 3'd2,
    KIND_PAYLOAD  = 3'd3,
    KIND_CHECKSUM = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    STAT_ONGOING  = 3'd0,
    STAT_GOOD     = 3'd1,
    STAT_BAD_SUM  = 3'd2,
    STAT_OVERSIZE = 3'd3,
    STAT_TIMEOUT  = 3'd4
  } status_t;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [2:0]       byte_kind;
    logic             frame_end;
    logic [2:0]       frame_status;
  } out_item_t;

  typedef struct packed {
    logic [ByteW-1:0] start_char_a;
    logic [ByteW-1:0] start_char_b;
    logic [ByteW-1:0] max_payload;
    logic [ByteW-1:0] idle_timeout_ticks;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/serial_frame_deframer.sv
`default_nettype none

// Byte-wise deframer for start, address, length, payload and additive checksum
// frames; timer ticks and received bytes share the input channel. Each transfer
// is registered on input, parsed combinationally against the parser state and
// its result, if any, is held in an output register, so one item is taken every
// cycle while the output side keeps up. The input register moves forward only
// when the output register is empty or being emptied in the same cycle, which
// is what sets the rate: one item per cycle. Each result passes through the
// input register and then the output register before its output transfer.
// Dropped bytes give no output transfer, and ticks give one only when they
// time out a partial frame.

module serial_frame_deframer
  import sfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ByteW-1:0]   cfg_data
);

  cfg_t      cfg;
  in_item_t  item;
  logic      item_valid;
  logic      advance;
  logic      has_result;
  out_item_t result;

  sfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  sfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (advance),
    .item       (item),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sfd_cfg_regs.sv
`default_nettype none

module sfd_cfg_regs
  import sfd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ByteW-1:0]   cfg_data,
  output cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_char_a       <= StartCharAReset;
      cfg.start_char_b       <= StartCharBReset;
      cfg.max_payload        <= MaxPayloadReset;
      cfg.idle_timeout_ticks <= IdleTicksReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_CHAR_A:       cfg.start_char_a       <= cfg_data;
        REG_START_CHAR_B:       cfg.start_char_b       <= cfg_data;
        REG_MAX_PAYLOAD:        cfg.max_payload        <= cfg_data;
        REG_IDLE_TIMEOUT_TICKS: cfg.idle_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sfd_parser.sv
`default_nettype none

module sfd_parser
  import sfd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     step,
  input  wire in_item_t item,
  output logic          has_result,
  output out_item_t     result
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ADDR  = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } phase_t;

  phase_t            parse_phase, parse_phase_next;
  logic [ByteW-1:0]  running_sum, running_sum_next;
  logic [ByteW-1:0]  frame_length, frame_length_next;
  logic [CountW-1:0] bytes_after_length, bytes_after_length_next;
  logic [ByteW-1:0]  idle_counter, idle_counter_next;

  logic [ByteW-1:0] b;
  logic [ByteW-1:0] sum_plus;
  logic [ByteW-1:0] idle_dec;

  assign b        = item.rx_byte;
  assign sum_plus = running_sum + b;
  assign idle_dec = idle_counter - 1'b1;

  always_comb begin
    parse_phase_next        = parse_phase;
    running_sum_next        = running_sum;
    frame_length_next       = frame_length;
    bytes_after_length_next = bytes_after_length;
    idle_counter_next       = idle_counter;
    has_result              = 1'b0;
    result.out_byte         = b;
    result.byte_kind        = KIND_START;
    result.frame_end        = 1'b0;
    result.frame_status     = STAT_ONGOING;

    if (item.req_type == REQ_TICK) begin
      result.out_byte = '0;
      if (idle_counter != '0) begin
        idle_counter_next = idle_dec;
        // Expiry drops only a frame that has started.
        if (idle_dec == '0 && parse_phase != PH_START) begin
          parse_phase_next        = PH_START;
          bytes_after_length_next = '0;
          has_result              = 1'b1;
          result.frame_end        = 1'b1;
          result.frame_status     = STAT_TIMEOUT;
        end
      end
    end else begin
      idle_counter_next = cfg.idle_timeout_ticks;
      case (parse_phase)
        PH_START: begin
          if (b == cfg.start_char_a || b == cfg.start_char_b) begin
            running_sum_next        = b;
            bytes_after_length_next = '0;
            parse_phase_next        = PH_ADDR;
            has_result              = 1'b1;
          end
        end
        PH_ADDR: begin
          running_sum_next = sum_plus;
          parse_phase_next = PH_LEN;
          has_result       = 1'b1;
          result.byte_kind = KIND_ADDRESS;
        end
        PH_LEN: begin
          has_result       = 1'b1;
          result.byte_kind = KIND_LENGTH;
          if (b <= cfg.max_payload) begin
            running_sum_next        = sum_plus;
            frame_length_next       = b;
            bytes_after_length_next = '0;
            parse_phase_next        = PH_BODY;
          end else begin
            parse_phase_next    = PH_START;
            result.frame_end    = 1'b1;
            result.frame_status = STAT_OVERSIZE;
          end
        end
        default: begin
          running_sum_next        = sum_plus;
          bytes_after_length_next = bytes_after_length + 1'b1;
          has_result              = 1'b1;
          if (bytes_after_length < {1'b0, frame_length}) begin
            result.byte_kind = KIND_PAYLOAD;
          end else begin
            parse_phase_next    = PH_START;
            result.byte_kind    = KIND_CHECKSUM;
            result.frame_end    = 1'b1;
            result.frame_status = (b == running_sum) ? STAT_GOOD : STAT_BAD_SUM;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_START;
      running_sum        <= '0;
      frame_length       <= '0;
      bytes_after_length <= '0;
      idle_counter       <= '0;
    end else if (step) begin
      parse_phase        <= parse_phase_next;
      running_sum        <= running_sum_next;
      frame_length       <= frame_length_next;
      bytes_after_length <= bytes_after_length_next;
      idle_counter       <= idle_counter_next;
    end
  end

endmodule

`default_nettype wire
